[sv/lsb_pkg.sv]
`default_nettype none
package lsb_pkg;

  localparam int unsigned GRID_POINTS = 5001;
  localparam int unsigned IDXW = $clog2(GRID_POINTS);
  localparam int unsigned XW = IDXW + 16;
  localparam int unsigned DW = (XW > 24) ? XW : 24;

  localparam int unsigned CFG_IDXW = 2;
  localparam int unsigned CFG_DW = 20;

  localparam logic [24:0] W_ONE = 25'd16777216;
  localparam logic [23:0] LOW_SCALAR_LIMIT = 24'd196608;

  localparam logic [19:0] SCALAR_WIDTH_RST = 20'd65536;
  localparam logic [19:0] VECTOR_WIDTH_RST = 20'd65536;
  localparam logic        SUPPRESS_RST = 1'b1;
  localparam logic [15:0] GRID_STEP_RST = 16'd655;

  typedef enum logic [CFG_IDXW-1:0] {
    CFG_SCALAR_WIDTH = 2'd0,
    CFG_VECTOR_WIDTH = 2'd1,
    CFG_SUPPRESS     = 2'd2,
    CFG_GRID_STEP    = 2'd3
  } lsb_cfg_e;

  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_READ = 1'b1
  } lsb_func_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WAIT,
    S_ADD_WR,
    S_RD_RAM,
    S_RD_DATA,
    S_RD_DIV,
    S_RESP
  } lsb_state_e;

  typedef enum logic [2:0] {
    W_IDLE,
    W_MUL,
    W_DEN,
    W_DIV,
    W_DONE
  } lsb_wphase_e;

  typedef enum logic [2:0] {
    M_IDLE,
    M_LO,
    M_HI,
    M_SUM,
    M_DIV,
    M_DONE
  } lsb_mphase_e;

  typedef struct packed {
    logic        func;
    logic [23:0] line_energy;
    logic [31:0] scalar_strength;
    logic [31:0] vector_strength;
    logic [12:0] grid_index;
  } lsb_req_t;

  typedef struct packed {
    logic [47:0] scalar_value;
    logic [47:0] vector_value;
    logic [47:0] scalar_peak;
    logic [12:0] scalar_peak_index;
    logic [47:0] vector_peak;
    logic [12:0] vector_peak_index;
    logic        saturated;
  } lsb_rsp_t;

endpackage
`default_nettype wire

[sv/lorentzian_spectrum_broadening_top.sv]
// Channel   Direction  Handshake             Payload
// request   in         start_i, busy_o       req_i  (lsb_req_t)
// result    out        done_o (strobe)       rsp_o  (lsb_rsp_t)
// config    in         cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// After reset the grid memory is swept clear, one entry a cycle, over all GRID_POINTS
// (5001) entries; busy_o is high throughout and configuration writes are still taken.
// An added line visits every grid point in turn, each through the 25-step restoring
// division in both Lorentzian weight units. A read scales the vector value with the
// 80-step divider unless the vector peak is zero; a read beyond the grid answers with
// zero values. The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
module lorentzian_spectrum_broadening_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire  lsb_pkg::lsb_req_t          req_i,
  output logic                             busy_o,
  output logic                             done_o,
  output lsb_pkg::lsb_rsp_t                rsp_o,
  input  wire                              cfg_we_i,
  input  wire  [lsb_pkg::CFG_IDXW-1:0]     cfg_idx_i,
  input  wire  [lsb_pkg::CFG_DW-1:0]       cfg_wdata_i
);
  import lsb_pkg::*;

  // Configuration registers and the squared widths derived from them.
  logic [19:0] sw_q, vw_q;
  logic        sup_q;
  logic [15:0] step_q;
  logic [39:0] sg2_q, vg2_q;

  lsb_state_e state_q, state_d;
  logic [IDXW-1:0] i_q, i_d;
  logic [IDXW-1:0] idx_q, idx_d;
  logic [XW-1:0]   x_q, x_d;
  logic [23:0]     e_q, e_d;
  logic [31:0]     s_q, s_d;
  logic [31:0]     v_q, v_d;
  logic [32:0]     cs_q, cs_d;
  logic [32:0]     cv_q, cv_d;
  logic [47:0]     sval_q, sval_d;
  logic [47:0]     vval_q, vval_d;
  logic [47:0]     speak_q, speak_d;
  logic [IDXW-1:0] spos_q, spos_d;
  logic [47:0]     vpeak_q, vpeak_d;
  logic [IDXW-1:0] vpos_q, vpos_d;
  logic [31:0]     rawmax_q, rawmax_d;
  logic            sat_q, sat_d;

  logic            ram_we, ram_re;
  logic [IDXW-1:0] ram_addr;
  logic [95:0]     ram_wdata, ram_rdata;

  logic            w_start, ws_done, wv_done;
  logic [24:0]     ws, wv;
  logic [DW-1:0]   xe, ee, line_gap;
  logic            m_start, m_done;
  logic [47:0]     m_q;

  logic            last;
  logic            in_range;
  logic [56:0]     mul_s, mul_v;
  logic [48:0]     sum_s, sum_v;
  logic [47:0]     new_s, new_v;

  lsb_ram #(
    .WIDTH(96),
    .DEPTH(GRID_POINTS)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  lsb_weight u_wscalar (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(w_start),
    .d_i    (line_gap),
    .g2_i   (sg2_q),
    .done_o (ws_done),
    .w_o    (ws)
  );

  lsb_weight u_wvector (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(w_start),
    .d_i    (line_gap),
    .g2_i   (vg2_q),
    .done_o (wv_done),
    .w_o    (wv)
  );

  lsb_muldiv u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(m_start),
    .a_i    (rawmax_q),
    .b_i    (ram_rdata[95:48]),
    .den_i  (vpeak_q),
    .done_o (m_done),
    .q_o    (m_q)
  );

  // The user is to send configuration writes only while the block is idle; unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= SCALAR_WIDTH_RST;
      vw_q   <= VECTOR_WIDTH_RST;
      sup_q  <= SUPPRESS_RST;
      step_q <= GRID_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (lsb_cfg_e'(cfg_idx_i))
        CFG_SCALAR_WIDTH: sw_q   <= cfg_wdata_i[19:0];
        CFG_VECTOR_WIDTH: vw_q   <= cfg_wdata_i[19:0];
        CFG_SUPPRESS:     sup_q  <= cfg_wdata_i[0];
        CFG_GRID_STEP:    step_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // The squares follow the widths in the next cycle, long before any weight uses them.
  always_ff @(posedge clk_i) begin
    sg2_q <= 40'(sw_q) * 40'(sw_q);
    vg2_q <= 40'(vw_q) * 40'(vw_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      i_q      <= '0;
      x_q      <= '0;
      speak_q  <= '0;
      spos_q   <= '0;
      vpeak_q  <= '0;
      vpos_q   <= '0;
      rawmax_q <= '0;
      sat_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      x_q      <= x_d;
      speak_q  <= speak_d;
      spos_q   <= spos_d;
      vpeak_q  <= vpeak_d;
      vpos_q   <= vpos_d;
      rawmax_q <= rawmax_d;
      sat_q    <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    e_q    <= e_d;
    s_q    <= s_d;
    v_q    <= v_d;
    cs_q   <= cs_d;
    cv_q   <= cv_d;
    sval_q <= sval_d;
    vval_q <= vval_d;
  end

  // Distance from the current grid energy to the line, both in Q16.16.
  assign xe       = DW'(x_q);
  assign ee       = DW'(e_q);
  assign line_gap = (xe >= ee) ? (xe - ee) : (ee - xe);

  assign last     = (i_q == IDXW'(GRID_POINTS - 1));
  assign in_range = (32'(req_i.grid_index) < GRID_POINTS);

  // Contribution is strength times the Q1.24 weight, back to Q16.16.
  assign mul_s = 57'(s_q) * 57'(ws);
  assign mul_v = 57'(v_q) * 57'(wv);

  assign sum_s = {1'b0, ram_rdata[47:0]} + 49'(cs_q);
  assign sum_v = {1'b0, ram_rdata[95:48]} + 49'(cv_q);
  assign new_s = sum_s[48] ? '1 : sum_s[47:0];
  assign new_v = sum_v[48] ? '1 : sum_v[47:0];

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    x_d       = x_q;
    idx_d     = idx_q;
    e_d       = e_q;
    s_d       = s_q;
    v_d       = v_q;
    cs_d      = cs_q;
    cv_d      = cv_q;
    sval_d    = sval_q;
    vval_d    = vval_q;
    speak_d   = speak_q;
    spos_d    = spos_q;
    vpeak_d   = vpeak_q;
    vpos_d    = vpos_q;
    rawmax_d  = rawmax_q;
    sat_d     = sat_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = i_q;
    ram_wdata = {new_v, new_s};
    w_start   = 1'b0;
    m_start   = 1'b0;
    done_o    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (last) begin
          i_d     = '0;
          state_d = S_IDLE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          if (lsb_func_e'(req_i.func) == FUNC_ADD) begin
            e_d = req_i.line_energy;
            // Low-energy lines lose their scalar strength when suppression is on.
            s_d = (sup_q && (req_i.line_energy <= LOW_SCALAR_LIMIT)) ?
                  '0 : req_i.scalar_strength;
            v_d = req_i.vector_strength;
            if (req_i.vector_strength > rawmax_q) begin
              rawmax_d = req_i.vector_strength;
            end
            i_d     = '0;
            x_d     = '0;
            sval_d  = '0;
            vval_d  = '0;
            state_d = S_ADD_RD;
          end else if (in_range) begin
            idx_d   = IDXW'(req_i.grid_index);
            state_d = S_RD_RAM;
          end else begin
            sval_d  = '0;
            vval_d  = '0;
            state_d = S_RESP;
          end
        end
      end
      S_ADD_RD: begin
        ram_re  = 1'b1;
        w_start = 1'b1;
        state_d = S_ADD_WAIT;
      end
      S_ADD_WAIT: begin
        if (ws_done && wv_done) begin
          cs_d    = mul_s[56:24];
          cv_d    = mul_v[56:24];
          state_d = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        ram_we = 1'b1;
        if (sum_s[48] || sum_v[48]) begin
          sat_d = 1'b1;
        end
        if (new_s > speak_q) begin
          speak_d = new_s;
          spos_d  = i_q;
        end
        if (new_v > vpeak_q) begin
          vpeak_d = new_v;
          vpos_d  = i_q;
        end
        if (last) begin
          state_d = S_RESP;
        end else begin
          i_d     = i_q + 1'b1;
          x_d     = x_q + XW'(step_q);
          state_d = S_ADD_RD;
        end
      end
      S_RD_RAM: begin
        ram_re   = 1'b1;
        ram_addr = idx_q;
        state_d  = S_RD_DATA;
      end
      S_RD_DATA: begin
        sval_d = ram_rdata[47:0];
        if (vpeak_q == '0) begin
          vval_d  = '0;
          state_d = S_RESP;
        end else begin
          m_start = 1'b1;
          state_d = S_RD_DIV;
        end
      end
      S_RD_DIV: begin
        if (m_done) begin
          vval_d  = m_q;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  assign rsp_o.scalar_value      = sval_q;
  assign rsp_o.vector_value      = vval_q;
  assign rsp_o.scalar_peak       = speak_q;
  assign rsp_o.scalar_peak_index = 13'(spos_q);
  assign rsp_o.vector_peak       = vpeak_q;
  assign rsp_o.vector_peak_index = 13'(vpos_q);
  assign rsp_o.saturated         = sat_q;

endmodule
`default_nettype wire

[sv/lsb_ram.sv]
`default_nettype none
module lsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] addr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

[sv/lsb_weight.sv]
`default_nettype none
module lsb_weight (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire  [lsb_pkg::DW-1:0]   d_i,
  input  wire  [39:0]              g2_i,
  output logic                     done_o,
  output logic [24:0]              w_o
);
  import lsb_pkg::*;

  lsb_wphase_e phase_q, phase_d;
  logic [DW-1:0] d_q, d_d;
  logic [61:0]   dd_q, dd_d;
  logic          far_q, far_d;
  logic [63:0]   den_q, den_d;
  logic          zero_q, zero_d;
  logic          one_q, one_d;
  logic [63:0]   rem_q, rem_d;
  logic [24:0]   quo_q, quo_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [63:0]   d64;
  logic [64:0]   sum65;
  logic [64:0]   trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= W_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    dd_q   <= dd_d;
    far_q  <= far_d;
    den_q  <= den_d;
    zero_q <= zero_d;
    one_q  <= one_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    d_d     = d_q;
    dd_d    = dd_q;
    far_d   = far_q;
    den_d   = den_q;
    zero_d  = zero_q;
    one_d   = one_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    done_o  = 1'b0;
    d64     = 64'(d_q);
    sum65   = {1'b0, dd_q, 2'b00} + 65'(g2_i);
    trial   = {rem_q, ((cnt_q == 5'd24) ? g2_i[0] : 1'b0)};
    unique case (phase_q)
      W_IDLE: begin
        if (start_i) begin
          d_d     = d_i;
          phase_d = W_MUL;
        end
      end
      W_MUL: begin
        dd_d    = 62'(d64[30:0]) * 62'(d64[30:0]);
        far_d   = |d64[63:31];
        phase_d = W_DEN;
      end
      W_DEN: begin
        den_d   = sum65[63:0];
        zero_d  = far_q | sum65[64];
        one_d   = (sum65 == '0);
        rem_d   = 64'(g2_i >> 1);
        quo_d   = '0;
        cnt_d   = 5'd24;
        phase_d = W_DIV;
      end
      W_DIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = 64'(trial - {1'b0, den_q});
          quo_d = {quo_q[23:0], 1'b1};
        end else begin
          rem_d = trial[63:0];
          quo_d = {quo_q[23:0], 1'b0};
        end
        if (cnt_q == '0) begin
          phase_d = W_DONE;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      W_DONE: begin
        done_o  = 1'b1;
        phase_d = W_IDLE;
      end
      default: phase_d = W_IDLE;
    endcase
  end

  assign w_o = zero_q ? '0 : (one_q ? W_ONE : quo_q);

endmodule
`default_nettype wire

[sv/lsb_muldiv.sv]
`default_nettype none
module lsb_muldiv (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [31:0] a_i,
  input  wire  [47:0] b_i,
  input  wire  [47:0] den_i,
  output logic        done_o,
  output logic [47:0] q_o
);
  import lsb_pkg::*;

  lsb_mphase_e phase_q, phase_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [31:0] a_q, a_d;
  logic [47:0] b_q, b_d;
  logic [47:0] den_q, den_d;
  logic [63:0] plo_q, plo_d;
  logic [47:0] phi_q, phi_d;
  logic [79:0] prod_q, prod_d;
  logic [47:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [48:0] trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= M_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    den_q  <= den_d;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    den_d   = den_q;
    plo_d   = plo_q;
    phi_d   = phi_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    done_o  = 1'b0;
    trial   = {rem_q, prod_q[cnt_q]};
    unique case (phase_q)
      M_IDLE: begin
        if (start_i) begin
          a_d     = a_i;
          b_d     = b_i;
          den_d   = den_i;
          phase_d = M_LO;
        end
      end
      M_LO: begin
        plo_d   = 64'(a_q) * 64'(b_q[31:0]);
        phase_d = M_HI;
      end
      M_HI: begin
        phi_d   = 48'(a_q) * 48'(b_q[47:32]);
        phase_d = M_SUM;
      end
      M_SUM: begin
        prod_d  = 80'(plo_q) + {phi_q, 32'b0};
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = 7'd79;
        phase_d = M_DIV;
      end
      M_DIV: begin
        // The quotient keeps its low 48 bits only.
        if (trial >= {1'b0, den_q}) begin
          rem_d = 48'(trial - {1'b0, den_q});
          quo_d = {quo_q[46:0], 1'b1};
        end else begin
          rem_d = trial[47:0];
          quo_d = {quo_q[46:0], 1'b0};
        end
        if (cnt_q == '0) begin
          phase_d = M_DONE;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      M_DONE: begin
        done_o  = 1'b1;
        phase_d = M_IDLE;
      end
      default: phase_d = M_IDLE;
    endcase
  end

  assign q_o = quo_q;

endmodule
`default_nettype wire

[sv/lsb_checker.sv]
`default_nettype none
module lsb_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire start_i,
  input wire busy_o,
  input wire done_o
);

  // A result is shown only while the block still holds off new requests.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe while idle");

  // An accepted request keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("not busy after accepting a request");

  // Coming out of reset the block is busy clearing its grid.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> busy_o)
    else $error("idle straight after reset");

  // One strobe per request, after which the block is idle again.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("result strobe repeated");

endmodule

bind lorentzian_spectrum_broadening_top lsb_checker u_lsb_checker (.*);
`default_nettype wire
